### design/dcss_pkg.sv
// dcss_pkg: shared types, register indexes and digit decode for the
// multiplexed seven-segment clock. No dependencies.
package dcss_pkg;

  // register indexes on the configuration channel
  localparam logic [0:0] REG_SECOND_PERIOD = 1'b0;
  localparam logic [0:0] REG_SCAN_PERIOD   = 1'b1;

  // reset values
  localparam logic [15:0] SECOND_PERIOD_RST = 16'd100;
  localparam logic [15:0] SCAN_PERIOD_RST   = 16'd25;
  localparam logic [5:0]  SECONDS_RST       = 6'd50;
  localparam logic [5:0]  MINUTES_RST       = 6'd8;
  localparam logic [4:0]  HOURS_RST         = 5'd15;

  // wrap points
  localparam logic [6:0] SECONDS_WRAP = 7'd60;
  localparam logic [6:0] MINUTES_WRAP = 7'd60;
  localparam logic [5:0] HOURS_WRAP   = 6'd24;

  localparam int unsigned DIGIT_COUNT = 4;
  localparam int unsigned IDX_W       = $clog2(DIGIT_COUNT);

  // digit positions in scan order
  localparam logic [IDX_W-1:0] DIG_HOUR_TENS = 2'd0;
  localparam logic [IDX_W-1:0] DIG_HOUR_ONES = 2'd1;
  localparam logic [IDX_W-1:0] DIG_MIN_TENS  = 2'd2;
  localparam logic [IDX_W-1:0] DIG_MIN_ONES  = 2'd3;

  // result word, first field in the high bits
  typedef struct packed {
    logic [5:0] seconds_now;
    logic [5:0] minutes_now;
    logic [4:0] hours_now;
    logic       dot_level;
    logic [3:0] digit_enable_n;
    logic [6:0] segments_n;
  } result_t;

  // tens digit of a value below 64, by reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [13:0] prod;
    prod = 14'(v) * 14'd205;
    return 4'(prod[13:11]);
  endfunction

  // ones digit from value and its tens digit
  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [3:0] t);
    logic [6:0] tx10;
    logic [6:0] diff;
    tx10 = {3'd0, t} * 7'd10;
    diff = 7'(v) - tx10;
    return diff[3:0];
  endfunction

  // active-low common-anode patterns, codes above nine fold back by ten
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0, 4'd10: p = 7'h40;
      4'd1, 4'd11: p = 7'h79;
      4'd2, 4'd12: p = 7'h24;
      4'd3, 4'd13: p = 7'h30;
      4'd4, 4'd14: p = 7'h19;
      4'd5, 4'd15: p = 7'h12;
      4'd6:        p = 7'h02;
      4'd7:        p = 7'h78;
      4'd8:        p = 7'h00;
      4'd9:        p = 7'h10;
      default:     p = 7'h40;
    endcase
    return p;
  endfunction

endpackage

### design/digital_clock_seven_segment_scan.sv
// digital_clock_seven_segment_scan: time keeping, digit scan and output
// skid buffer of the multiplexed seven-segment clock. Depends on dcss_pkg.
//
// Usage: every word on the s_axis channel is one timer strobe; bit0 of
// tdata is the tick flag (a word with tick low leaves the state alone).
// Each accepted word yields exactly one m_axis word carrying the segment
// and digit enable latches, the dot level and the current time.
// The two dividers reload from the periods on the cfg channel (index 0:
// second period, index 1: scan period); a period of zero counts as one and
// a new period takes effect at the next reload. Write them only when idle.
// Throughput: one word per cycle while the output buffer is not full, set
// by the single register stage holding time and dividers.
// A two-entry output buffer (output register plus skid register) keeps
// the input taking a word while one result waits; when both are full the
// input stalls until m_axis_tready_i drains one.
// Reset: time 15:08:50, dividers at 100 and 25, all segments and digits on,
// dot low, periods back to 100 and 25, output buffer empty.
module digital_clock_seven_segment_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream, tdata: [0] tick, [7:1] zero
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // output stream, tdata: [6:0] segments_n, [10:7] digit_enable_n,
  // [11] dot_level, [16:12] hours_now, [22:17] minutes_now,
  // [28:23] seconds_now, [31:29] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] sec_period_q, scan_period_q;
  logic [15:0] sec_div_q, sec_div_d;
  logic [15:0] scan_div_q, scan_div_d;
  logic [5:0]  seconds_q, seconds_d;
  logic [5:0]  minutes_q, minutes_d;
  logic [4:0]  hours_q, hours_d;
  logic [dcss_pkg::IDX_W-1:0] digit_idx_q, digit_idx_d;
  logic [6:0]  seg_q, seg_d;
  logic [3:0]  en_q, en_d;
  logic        dot_q, dot_d;

  logic        accept, tick, sec_exp, scan_exp;
  logic [6:0]  sec_inc, min_inc;
  logic [5:0]  min_mid, hr_inc;
  logic [5:0]  scan_val;
  logic [3:0]  tens, ones, digit_val;
  dcss_pkg::result_t res_d;

  logic        m_valid_q, skid_valid_q, m_take;
  dcss_pkg::result_t m_data_q, skid_data_q;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign tick            = s_axis_tdata_i[0];
  assign m_take          = m_valid_q && m_axis_tready_i;

  // period registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_period_q  <= dcss_pkg::SECOND_PERIOD_RST;
      scan_period_q <= dcss_pkg::SCAN_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dcss_pkg::REG_SECOND_PERIOD: sec_period_q  <= cfg_data_i;
        dcss_pkg::REG_SCAN_PERIOD:   scan_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // dividers, reload on expiry with zero period read as one
  always_comb begin
    sec_exp  = (sec_div_q <= 16'd1);
    scan_exp = (scan_div_q <= 16'd1);
    if (sec_exp) begin
      sec_div_d = (sec_period_q == 16'd0) ? 16'd1 : sec_period_q;
    end else begin
      sec_div_d = sec_div_q - 16'd1;
    end
    if (scan_exp) begin
      scan_div_d = (scan_period_q == 16'd0) ? 16'd1 : scan_period_q;
    end else begin
      scan_div_d = scan_div_q - 16'd1;
    end
  end

  // time advance with carries
  always_comb begin
    seconds_d = seconds_q;
    minutes_d = minutes_q;
    hours_d   = hours_q;
    dot_d     = dot_q;
    sec_inc   = 7'(seconds_q) + 7'd1;
    min_inc   = 7'(minutes_q);
    if (sec_exp) begin
      if (sec_inc >= dcss_pkg::SECONDS_WRAP) begin
        seconds_d = 6'd0;
        min_inc   = 7'(minutes_q) + 7'd1;
      end else begin
        seconds_d = sec_inc[5:0];
      end
    end
    hr_inc  = 6'(hours_q);
    min_mid = min_inc[5:0];
    if (min_inc >= dcss_pkg::MINUTES_WRAP) begin
      min_mid = 6'd0;
      hr_inc  = 6'(hours_q) + 6'd1;
    end
    if (sec_exp) begin
      minutes_d = min_mid;
      hours_d   = (hr_inc >= dcss_pkg::HOURS_WRAP) ? 5'd0 : hr_inc[4:0];
      dot_d     = !dot_q;
    end
  end

  // digit scan on the updated time
  always_comb begin
    case (digit_idx_q)
      dcss_pkg::DIG_HOUR_TENS,
      dcss_pkg::DIG_HOUR_ONES: scan_val = 6'(hours_d);
      default:                 scan_val = minutes_d;
    endcase
    tens = dcss_pkg::tens_of(scan_val);
    ones = dcss_pkg::ones_of(scan_val, tens);
    case (digit_idx_q)
      dcss_pkg::DIG_HOUR_TENS: digit_val = tens;
      dcss_pkg::DIG_MIN_TENS:  digit_val = tens;
      dcss_pkg::DIG_HOUR_ONES: digit_val = ones;
      dcss_pkg::DIG_MIN_ONES:  digit_val = ones;
      default:                 digit_val = ones;
    endcase
    seg_d       = seg_q;
    en_d        = en_q;
    digit_idx_d = digit_idx_q;
    if (scan_exp) begin
      seg_d       = dcss_pkg::seg_pattern(digit_val);
      en_d        = ~(4'd1 << digit_idx_q);
      digit_idx_d = digit_idx_q + 2'd1;
    end
  end

  // result word, from the state as it stands after this word
  always_comb begin
    res_d.seconds_now = seconds_q;
    res_d.minutes_now = minutes_q;
    res_d.hours_now   = hours_q;
    res_d.dot_level   = dot_q;
    res_d.digit_enable_n = en_q;
    res_d.segments_n  = seg_q;
    if (tick) begin
      res_d.seconds_now    = seconds_d;
      res_d.minutes_now    = minutes_d;
      res_d.hours_now      = hours_d;
      res_d.dot_level      = dot_d;
      res_d.digit_enable_n = en_d;
      res_d.segments_n     = seg_d;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_div_q   <= dcss_pkg::SECOND_PERIOD_RST;
      scan_div_q  <= dcss_pkg::SCAN_PERIOD_RST;
      seconds_q   <= dcss_pkg::SECONDS_RST;
      minutes_q   <= dcss_pkg::MINUTES_RST;
      hours_q     <= dcss_pkg::HOURS_RST;
      digit_idx_q <= dcss_pkg::DIG_HOUR_TENS;
      seg_q       <= 7'd0;
      en_q        <= 4'd0;
      dot_q       <= 1'b0;
    end else if (accept && tick) begin
      sec_div_q   <= sec_div_d;
      scan_div_q  <= scan_div_d;
      seconds_q   <= seconds_d;
      minutes_q   <= minutes_d;
      hours_q     <= hours_d;
      digit_idx_q <= digit_idx_d;
      seg_q       <= seg_d;
      en_q        <= en_d;
      dot_q       <= dot_d;
    end
  end

  // output register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q    <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (m_valid_q && !m_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        m_valid_q <= 1'b1;
      end
    end else if (m_take) begin
      m_valid_q <= 1'b0;
    end
  end

  // payload moves
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_take) begin
        m_data_q <= skid_data_q;
      end
    end else if (accept) begin
      if (m_valid_q && !m_take) begin
        skid_data_q <= res_d;
      end else begin
        m_data_q <= res_d;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'd0, m_data_q};

`ifndef SYNTH
  // skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> m_valid_q)
    else $error("skid register valid while output register empty");

  // time stays in range
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seconds_q < 6'd60) && (minutes_q < 6'd60) && (hours_q < 5'd24))
    else $error("time register out of range");

  // digit enable is all-on after reset or exactly one digit low
  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_q == 4'd0) || $onehot(~en_q))
    else $error("digit enable not one-hot low");

  // dot toggles on each second expiry
  a_dot_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tick && (sec_div_q <= 16'd1)) |=> (dot_q != $past(dot_q)))
    else $error("dot did not toggle on second expiry");
`endif

endmodule
